@@ sv/mpsjf_pkg.sv @@
// Package for the multilevel preemptive SJF scheduler.
// Holds the shared constants, result codes, control state and level command types.
`default_nettype none
package mpsjf_pkg;
    localparam int ID_BITS = 6;

    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_DROP   = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_INS,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic ins;
        logic ext;
    } t_lvl_cmd;
endpackage
`default_nettype wire

@@ sv/mpsjf_cell.sv @@
// One entry of a sorted level queue.
// Depends on mpsjf_pkg; chained by mpsjf_level.
`default_nettype none
module mpsjf_cell #(
    parameter int KEY_W = 22
) (
    input  wire                    i_clk,
    input  mpsjf_pkg::t_lvl_cmd    i_cmd,
    input  wire                    i_vld,
    input  wire  [KEY_W-1:0]       i_new,
    input  wire  [KEY_W-1:0]       i_prev_key,
    input  wire                    i_prev_g,
    input  wire  [KEY_W-1:0]       i_next_key,
    output logic [KEY_W-1:0]       o_key,
    output logic                   o_g
);
    import mpsjf_pkg::*;

    logic [KEY_W-1:0] r_key;

    // entry moves up on insert when the new key sorts strictly before it or the entry is empty
    assign o_g   = !i_vld || (i_new < r_key);
    assign o_key = r_key;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && o_g) begin
            r_key <= i_prev_g ? i_prev_key : i_new;
        end else if (i_cmd.ext) begin
            r_key <= i_next_key;
        end
    end
endmodule
`default_nettype wire

@@ sv/mpsjf_level.sv @@
// Sorted queue for one priority level: a row of cells plus a fill count.
// Depends on mpsjf_pkg and mpsjf_cell.
`default_nettype none
module mpsjf_level #(
    parameter int KEY_W    = 22,
    parameter int MAX_JOBS = 64,
    parameter int CW       = 7
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mpsjf_pkg::t_lvl_cmd i_cmd,
    input  wire  [KEY_W-1:0]    i_key,
    output logic [KEY_W-1:0]    o_head,
    output logic [CW-1:0]       o_cnt
);
    import mpsjf_pkg::*;

    logic [CW-1:0]    r_cnt;
    logic [KEY_W-1:0] w_key [MAX_JOBS];
    logic             w_g   [MAX_JOBS];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_JOBS; gi++) begin : g_cell
            logic [KEY_W-1:0] w_pk;
            logic [KEY_W-1:0] w_nk;
            logic             w_pg;
            if (gi == 0) begin : g_first
                assign w_pk = i_key;
                assign w_pg = 1'b0;
            end else begin : g_mid
                assign w_pk = w_key[gi-1];
                assign w_pg = w_g[gi-1];
            end
            if (gi == MAX_JOBS - 1) begin : g_last
                assign w_nk = w_key[gi];
            end else begin : g_inner
                assign w_nk = w_key[gi+1];
            end
            mpsjf_cell #(.KEY_W(KEY_W)) u_cell (
                .i_clk      (i_clk),
                .i_cmd      (i_cmd),
                .i_vld      (32'(r_cnt) > 32'(gi)),
                .i_new      (i_key),
                .i_prev_key (w_pk),
                .i_prev_g   (w_pg),
                .i_next_key (w_nk),
                .o_key      (w_key[gi]),
                .o_g        (w_g[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.ins) begin
            r_cnt <= r_cnt + CW'(1);
        end else if (i_cmd.ext) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_head = w_key[0];
    assign o_cnt  = r_cnt;
endmodule
`default_nettype wire

@@ sv/multilevel_preemptive_sjf_scheduler.sv @@
// Top level of the multilevel preemptive SJF scheduler: control, running job, levels.
// Depends on mpsjf_pkg and mpsjf_level.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  input   | in        | i_valid / o_ready  | i_op i_job_id i_burst i_priority_req
//  output  | out       | o_valid / i_ready  | o_kind o_tick_time o_run_valid o_run_job
//          |           |                    | o_first_start o_done_valid
//
// An item passes through accept, execute and hand-off to the output register; a tick
// that replaces the head of the running job's own level adds an insert step after
// execute, the second operation on that level's cell row. The output register stalls
// the control only when a result is still waiting there. Synchronous active-low reset
// clears counts, running job, started map and time; cell contents need no reset.
`default_nettype none
module multilevel_preemptive_sjf_scheduler #(
    parameter int LEVELS     = 5,
    parameter int MAX_JOBS   = 64,
    parameter int BURST_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_op,
    input  wire  [5:0]  i_job_id,
    input  wire  [15:0] i_burst,
    input  wire  [2:0]  i_priority_req,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_tick_time,
    output logic        o_run_valid,
    output logic [5:0]  o_run_job,
    output logic        o_first_start,
    output logic        o_done_valid
);
    import mpsjf_pkg::*;

    localparam int KEY_W = BURST_BITS + ID_BITS;
    localparam int CW    = $clog2(MAX_JOBS + 1);
    localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam logic [31:0] BMAX = 32'((64'(1) << BURST_BITS) - 64'(1));

    t_state r_state, n_state;

    // latched item
    logic                  r_op;
    logic [ID_BITS-1:0]    r_id;
    logic [BURST_BITS-1:0] r_burst;
    logic [LW-1:0]         r_lv;

    // running job
    logic                  r_cur_valid;
    logic [ID_BITS-1:0]    r_cur_job;
    logic [LW-1:0]         r_cur_lv;
    logic [BURST_BITS-1:0] r_cur_rem;
    logic [63:0]           r_started;
    logic [31:0]           r_time;

    // deferred insert for an own-level replace
    logic [LW-1:0]         r_ins2_lv;
    logic [KEY_W-1:0]      r_ins2_key;

    // pending result
    logic [1:0]            r_p_kind;
    logic [31:0]           r_p_time;
    logic                  r_p_rv;
    logic [5:0]            r_p_job;
    logic                  r_p_first;
    logic                  r_p_done;

    // output register
    logic                  r_ovalid;
    logic [1:0]            r_o_kind;
    logic [31:0]           r_o_time;
    logic                  r_o_rv;
    logic [5:0]            r_o_job;
    logic                  r_o_first;
    logic                  r_o_done;

    logic [KEY_W-1:0]      w_head [LEVELS];
    logic [CW-1:0]         w_cnt  [LEVELS];
    t_lvl_cmd              w_cmd  [LEVELS];
    logic [KEY_W-1:0]      w_lkey [LEVELS];

    // input sanitizing
    logic [31:0]           w_b32;
    logic [BURST_BITS-1:0] w_bsat;
    logic [4:0]            w_pr;
    logic [LW-1:0]         w_plv;

    // execute-step decisions
    logic                  c_any;
    logic [LW-1:0]         c_hi;
    logic                  c_ins_en, c_ext_en, c_ins2_en;
    logic [LW-1:0]         c_ins_lv, c_ext_lv;
    logic [KEY_W-1:0]      c_ins_key, c_run_key;
    logic                  c_sel_valid;
    logic [KEY_W-1:0]      c_sel_key;
    logic [LW-1:0]         c_sel_lv;
    logic [BURST_BITS-1:0] c_rem_dec;
    logic                  c_first, c_done;
    logic [1:0]            c_kind;
    logic                  c_out_free;

    // saturate burst to its range and force at least one tick; clamp priority to 1..LEVELS
    always_comb begin
        w_b32  = 32'(i_burst);
        w_bsat = (w_b32 > BMAX) ? BURST_BITS'(BMAX) : BURST_BITS'(w_b32);
        if (w_bsat == '0) begin
            w_bsat = BURST_BITS'(1);
        end
        w_pr = 5'(i_priority_req);
        if (w_pr == 5'd0) begin
            w_pr = 5'd1;
        end
        if (32'(w_pr) > 32'(LEVELS)) begin
            w_pr = 5'(LEVELS);
        end
        w_plv = LW'(w_pr - 5'd1);
    end

    // highest-priority (lowest-numbered) non-empty level
    always_comb begin
        c_any = 1'b0;
        c_hi  = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (w_cnt[l] != '0) begin
                c_any = 1'b1;
                c_hi  = LW'(l);
            end
        end
    end

    // pick, preempt and run one tick; or route an arrival
    always_comb begin
        c_ins_en    = 1'b0;
        c_ext_en    = 1'b0;
        c_ins2_en   = 1'b0;
        c_ins_lv    = r_cur_lv;
        c_ext_lv    = c_hi;
        c_run_key   = {r_cur_rem, r_cur_job};
        c_ins_key   = c_run_key;
        c_sel_valid = r_cur_valid;
        c_sel_key   = c_run_key;
        c_sel_lv    = r_cur_lv;
        c_kind      = KIND_TICK;
        c_first     = 1'b0;
        c_done      = 1'b0;
        if (r_op == OP_ARRIVE) begin
            c_ins_lv  = r_lv;
            c_ins_key = {r_burst, r_id};
            if (32'(w_cnt[r_lv]) < 32'(MAX_JOBS)) begin
                c_ins_en = 1'b1;
                c_kind   = KIND_ACCEPT;
            end else begin
                c_kind   = KIND_DROP;
            end
        end else if (!r_cur_valid) begin
            if (c_any) begin
                c_ext_en    = 1'b1;
                c_sel_valid = 1'b1;
                c_sel_key   = w_head[c_hi];
                c_sel_lv    = c_hi;
            end
        end else if (c_any && (c_hi <= r_cur_lv)) begin
            if (c_hi == r_cur_lv) begin
                // own level: swap only when its head beats the running job
                if (w_head[c_hi] < c_run_key) begin
                    c_ext_en  = 1'b1;
                    c_ins2_en = 1'b1;
                    c_sel_key = w_head[c_hi];
                end
            end else if (32'(w_cnt[r_cur_lv]) < 32'(MAX_JOBS)) begin
                c_ins_en  = 1'b1;
                c_ext_en  = 1'b1;
                c_sel_key = w_head[c_hi];
                c_sel_lv  = c_hi;
            end
        end
        c_rem_dec = c_sel_key[KEY_W-1:ID_BITS] - BURST_BITS'(1);
        if (c_sel_valid) begin
            c_first = !r_started[c_sel_key[ID_BITS-1:0]];
            c_done  = (c_rem_dec == '0);
        end
    end

    // level commands
    always_comb begin
        for (int l = 0; l < LEVELS; l++) begin
            w_cmd[l].ins = ((r_state == ST_EXEC) && c_ins_en && (c_ins_lv == LW'(l)))
                        || ((r_state == ST_INS) && (r_ins2_lv == LW'(l)));
            w_cmd[l].ext = (r_state == ST_EXEC) && c_ext_en && (c_ext_lv == LW'(l));
            w_lkey[l]    = (r_state == ST_INS) ? r_ins2_key : c_ins_key;
        end
    end

    genvar gl;
    generate
        for (gl = 0; gl < LEVELS; gl++) begin : g_lvl
            mpsjf_level #(.KEY_W(KEY_W), .MAX_JOBS(MAX_JOBS), .CW(CW)) u_level (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd[gl]),
                .i_key   (w_lkey[gl]),
                .o_head  (w_head[gl]),
                .o_cnt   (w_cnt[gl])
            );
        end
    endgenerate

    assign c_out_free = !r_ovalid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_EXEC;
            ST_EXEC: n_state = c_ins2_en ? ST_INS : ST_OUT;
            ST_INS:  n_state = ST_OUT;
            ST_OUT:  if (c_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_ready = (r_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur_valid <= 1'b0;
            r_cur_job   <= '0;
            r_cur_lv    <= '0;
            r_cur_rem   <= '0;
            r_started   <= '0;
            r_time      <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_EXEC) && (r_op == OP_TICK)) begin
                r_time <= r_time + 32'd1;
                if (c_sel_valid) begin
                    r_cur_valid <= !c_done;
                    r_cur_job   <= c_sel_key[ID_BITS-1:0];
                    r_cur_lv    <= c_sel_lv;
                    r_cur_rem   <= c_rem_dec;
                    r_started[c_sel_key[ID_BITS-1:0]] <= !c_done;
                end
            end
            if ((r_state == ST_OUT) && c_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op    <= i_op;
            r_id    <= i_job_id;
            r_burst <= w_bsat;
            r_lv    <= w_plv;
        end
        if (r_state == ST_EXEC) begin
            r_ins2_lv  <= r_cur_lv;
            r_ins2_key <= c_run_key;
            r_p_kind   <= c_kind;
            r_p_time   <= r_time;
            r_p_rv     <= (r_op == OP_TICK) && c_sel_valid;
            r_p_job    <= ((r_op == OP_TICK) && c_sel_valid) ? c_sel_key[ID_BITS-1:0] : '0;
            r_p_first  <= (r_op == OP_TICK) && c_first;
            r_p_done   <= (r_op == OP_TICK) && c_done;
        end
        if ((r_state == ST_OUT) && c_out_free) begin
            r_o_kind  <= r_p_kind;
            r_o_time  <= r_p_time;
            r_o_rv    <= r_p_rv;
            r_o_job   <= r_p_job;
            r_o_first <= r_p_first;
            r_o_done  <= r_p_done;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_kind        = r_o_kind;
    assign o_tick_time   = r_o_time;
    assign o_run_valid   = r_o_rv;
    assign o_run_job     = r_o_job;
    assign o_first_start = r_o_first;
    assign o_done_valid  = r_o_done;
endmodule
`default_nettype wire
